@@ sv/gf256_arithmetic_unit_defines.svh @@
// Assertion macros for the checker file of the GF(2^8) unit.
// The macros expect a signal named clk in the using scope; all but the last also use rst_n.
`ifndef GF256_ARITHMETIC_UNIT_DEFINES_SVH
`define GF256_ARITHMETIC_UNIT_DEFINES_SVH

// Implication in the same cycle, ignored while reset is low.
`define GFAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, ignored while reset is low.
`define GFAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication in the next cycle, checked during reset as well.
`define GFAU_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/gfau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_pkg
// Types and constants shared by the GF(2^8) arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

  localparam int CELLS = 8;

  localparam logic [8:0] POLY_RESET = 9'h11B;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_MUL = 2'd1;
  localparam logic [1:0] CMD_INV = 2'd2;

  // Passes through the cell chain for one multiply and one inverse.
  localparam logic [3:0] MUL_PASSES = 4'd1;
  localparam logic [3:0] INV_PASSES = 4'd8;

  // One shift-and-add multiply in flight: partial sum, shifted
  // multiplicand and the multiplier bits not yet consumed.
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] m;
    logic [7:0] b;
  } lane_t;

endpackage

@@ sv/gf256_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit
// GF(2^8) add, multiply and invert with a programmable field polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one request per handshake; in_tuser holds the command, in_tdata
//            holds operand_a (bits 7:0) and operand_b (bits 15:8).
//   out_*  : one result byte per request, in request order.
//   cfg_*  : write of the 9-bit field polynomial; always ready. Write only
//            while no request is outstanding.
// One request is worked on at a time. Add and unused commands are settled
// on accept; multiply and invert first run through the cell chain. Multiply is
// one pass through the 8-cell shift-and-add chain; invert is 8 passes,
// squaring and accumulating a^254 in two lanes side by side.
// The next request is taken as soon as the previous result has moved into
// the output register, even if that result is still waiting there.
// Reset restores the polynomial to 0x11B and empties the output register.
// While out_tready is low a finished result is held, and a request already
// accepted waits after its computation until the output register frees up.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] operand_a, [15:8] operand_b
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] result
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // [8:0] field_polynomial
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [8:0] poly_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [3:0] pass_r, pass_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [7:0] a_r, a_nxt;
  logic [7:0] b_r, b_nxt;
  logic [7:0] res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  gfau_pkg::lane_t sq_in, sq_out, acc_in, acc_out;

  logic       in_fire;
  logic       out_free;
  logic [3:0] last_pass;
  logic       run_done;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign last_pass = (cmd_r == gfau_pkg::CMD_MUL) ? gfau_pkg::MUL_PASSES
                                                  : gfau_pkg::INV_PASSES;
  assign run_done  = (state_r == ST_RUN) && (cnt_r == 3'd0) && (pass_r == last_pass);

  // First pass takes the operands; later passes feed back the chain outputs.
  always_comb begin
    if (pass_r == 4'd0) begin
      sq_in.acc  = 8'h00;
      sq_in.m    = a_r;
      sq_in.b    = (cmd_r == gfau_pkg::CMD_MUL) ? b_r : a_r;
      acc_in.acc = 8'h00;
      acc_in.m   = 8'h01;
      acc_in.b   = 8'h01;
    end else begin
      sq_in.acc  = 8'h00;
      sq_in.m    = sq_out.acc;
      sq_in.b    = sq_out.acc;
      acc_in.acc = 8'h00;
      acc_in.m   = acc_out.acc;
      acc_in.b   = sq_out.acc;
    end
  end

  gfau_chain u_sq_chain (
    .clk    (clk),
    .red    (poly_r[7:0]),
    .lane_i (sq_in),
    .lane_o (sq_out)
  );

  gfau_chain u_acc_chain (
    .clk    (clk),
    .red    (poly_r[7:0]),
    .lane_i (acc_in),
    .lane_o (acc_out)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pass_nxt      = pass_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt  = in_tuser;
          a_nxt    = in_tdata[7:0];
          b_nxt    = in_tdata[15:8];
          cnt_nxt  = 3'd0;
          pass_nxt = 4'd0;
          if (in_tuser inside {gfau_pkg::CMD_MUL, gfau_pkg::CMD_INV}) begin
            state_nxt = ST_RUN;
          end else begin
            res_nxt   = (in_tuser == gfau_pkg::CMD_ADD) ? (in_tdata[7:0] ^ in_tdata[15:8])
                                                        : 8'h00;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_RUN: begin
        if (run_done) begin
          res_nxt   = (cmd_r == gfau_pkg::CMD_MUL) ? sq_out.acc : acc_out.acc;
          state_nxt = ST_HOLD;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            pass_nxt = pass_r + 4'd1;
          end
        end
      end
      ST_HOLD: begin
        // wait for the output register to drain
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      poly_r      <= gfau_pkg::POLY_RESET;
      cnt_r       <= 3'd0;
      pass_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        poly_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/gfau_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_cell
// One shift-and-add step: add the multiplicand on the low multiplier bit,
// double and reduce the multiplicand, shift the multiplier down.
// ----------------------------------------------------------------------------
module gfau_cell (
  input  logic              clk,
  input  logic [7:0]        red,
  input  gfau_pkg::lane_t   lane_i,
  output gfau_pkg::lane_t   lane_o
);

  gfau_pkg::lane_t lane_r;
  gfau_pkg::lane_t lane_nxt;

  always_comb begin
    lane_nxt.acc = lane_i.acc ^ (lane_i.b[0] ? lane_i.m : 8'h00);
    // bit 8 drops out; fold it back with the low polynomial bits
    lane_nxt.m   = {lane_i.m[6:0], 1'b0} ^ (lane_i.m[7] ? red : 8'h00);
    lane_nxt.b   = {1'b0, lane_i.b[7:1]};
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_o = lane_r;

endmodule

@@ sv/gfau_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_chain
// Row of multiply cells, each with its own output register; a product leaves
// the last cell after passing through the register of every cell.
// ----------------------------------------------------------------------------
module gfau_chain (
  input  logic              clk,
  input  logic [7:0]        red,
  input  gfau_pkg::lane_t   lane_i,
  output gfau_pkg::lane_t   lane_o
);

  gfau_pkg::lane_t stage [gfau_pkg::CELLS+1];

  assign stage[0] = lane_i;

  for (genvar i = 0; i < gfau_pkg::CELLS; i++) begin : g_cell
    gfau_cell u_cell (
      .clk    (clk),
      .red    (red),
      .lane_i (stage[i]),
      .lane_o (stage[i+1])
    );
  end

  assign lane_o = stage[gfau_pkg::CELLS];

endmodule

@@ sv/gfau_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfau_checker
// Port-level checks of the GF(2^8) unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "gf256_arithmetic_unit_defines.svh"

module gfau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // A stalled result holds its value.
  `GFAU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "stalled result changed")

  // One request at a time: no new request right after an accept.
  `GFAU_ASSERT_NEXT(a_one_busy, in_tvalid && in_tready, !in_tready, "request taken while busy")

  // A result appears only when the unit has just been busy (in_tready low).
  `GFAU_ASSERT_NOW(a_out_after_busy, $rose(out_tvalid), !$past(in_tready), "result without request")

  // Reset empties the output register.
  `GFAU_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid, "output valid after reset")

endmodule

bind gf256_arithmetic_unit gfau_checker u_gfau_checker (.*);
